/* sv/fpa_pkg.sv */
// shared types and opcodes of the fixed-point alu
package fpa_pkg;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_MIN = 4'd4;
	localparam logic [3:0] OP_MAX = 4'd5;
	localparam logic [3:0] OP_INC = 4'd6;
	localparam logic [3:0] OP_DEC = 4'd7;
	localparam logic [3:0] OP_I2F = 4'd8;
	localparam logic [3:0] OP_F2I = 4'd9;

	localparam logic signed [31:0] RAW_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] RAW_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [3:0]         req_type;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_raw;
		logic               a_less;
		logic               a_equal;
		logic               a_greater;
		logic               overflow;
		logic               divide_by_zero;
	} rsp_t;

endpackage

/* sv/fixed_point_alu.sv */
// signed fixed-point alu, fully pipelined with a bit-per-stage divider
//
// request channel: req (opcode and two raw operands) with req_valid / req_stall.
// response channel: rsp (raw result and flags) with rsp_valid / rsp_stall.
// a transaction happens on a rising edge where valid is high and stall is low.
// every opcode passes the same stages: one input stage, one restoring-divider
// stage per quotient bit (32 + FRAC_BITS of them), one rounding stage and the
// output register. the 32x32 multiply sits in the first divider stage.
// throughput is one transaction per cycle except while the pipe holds.
// multiply and divide round half away from zero; results saturate to 32 bits
// and raise overflow. divide by zero gives 0 with divide_by_zero set.
// the compare flags always compare operand_a with operand_b.
// reset clears all valid bits, so the pipe comes up empty.
// when the receiver stalls a waiting response, the whole pipe holds and
// req_stall rises; nothing is lost or repeated.
module fixed_point_alu
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int DVW = 32 + FRAC_BITS;

	typedef struct packed {
		logic [3:0]        op;
		logic              lt;
		logic              eq;
		logic              gt;
		logic              neg;
		logic              dz;
		logic [31:0]       sres;
		logic              sovf;
		logic [31:0]       ma;
		logic [31:0]       mb;
		logic [63:0]       prod;
		logic [31:0]       rem;
		logic [DVW-1:0]    dvd;
	} pipe_t;

	typedef struct packed {
		logic        use_mag;
		logic        neg;
		logic [63:0] mag;
		logic [31:0] sres;
		logic        sovf;
		logic        lt;
		logic        eq;
		logic        gt;
		logic        dz;
	} fin_t;

	logic           en;
	logic [DVW:0]   vld_s;
	pipe_t          pipe_s [0:DVW];
	logic           vld_fin_s;
	fin_t           fin_s;
	logic           rsp_valid_q;
	rsp_t           rsp_q;

	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// input stage: short ops finish here, magnitudes set up for mul and div
	pipe_t       in_p;
	logic [32:0] sum_w;
	logic [32:0] dif_w;
	logic signed [31:0] hi_w;
	logic signed [31:0] a_w;
	logic signed [31:0] b_w;

	always_comb begin
		a_w   = req.operand_a;
		b_w   = req.operand_b;
		sum_w = {a_w[31], a_w} + {b_w[31], b_w};
		dif_w = {a_w[31], a_w} - {b_w[31], b_w};
		hi_w  = a_w >>> (31 - FRAC_BITS);
		in_p      = '0;
		in_p.op   = req.req_type;
		in_p.lt   = a_w < b_w;
		in_p.eq   = a_w == b_w;
		in_p.gt   = a_w > b_w;
		in_p.neg  = a_w[31] ^ b_w[31];
		in_p.dz   = (req.req_type == OP_DIV) && (b_w == 32'sd0);
		in_p.ma   = a_w[31] ? 32'(-a_w) : 32'(a_w);
		in_p.mb   = b_w[31] ? 32'(-b_w) : 32'(b_w);
		in_p.dvd  = {in_p.ma, {FRAC_BITS{1'b0}}};
		in_p.sres = '0;
		in_p.sovf = 1'b0;
		unique case (req.req_type)
			OP_ADD: begin
				in_p.sovf = sum_w[32] != sum_w[31];
				in_p.sres = in_p.sovf ? (sum_w[32] ? RAW_MIN : RAW_MAX) : sum_w[31:0];
			end
			OP_SUB: begin
				in_p.sovf = dif_w[32] != dif_w[31];
				in_p.sres = in_p.sovf ? (dif_w[32] ? RAW_MIN : RAW_MAX) : dif_w[31:0];
			end
			OP_MIN: in_p.sres = (a_w < b_w) ? a_w : b_w;
			OP_MAX: in_p.sres = (a_w > b_w) ? a_w : b_w;
			OP_INC: begin
				in_p.sovf = a_w == RAW_MAX;
				in_p.sres = in_p.sovf ? RAW_MAX : 32'(a_w + 32'sd1);
			end
			OP_DEC: begin
				in_p.sovf = a_w == RAW_MIN;
				in_p.sres = in_p.sovf ? RAW_MIN : 32'(a_w - 32'sd1);
			end
			OP_I2F: begin
				in_p.sovf = !(hi_w == 32'sd0 || hi_w == -32'sd1);
				in_p.sres = in_p.sovf ? (a_w[31] ? RAW_MIN : RAW_MAX) : (a_w <<< FRAC_BITS);
			end
			OP_F2I:  in_p.sres = a_w >>> FRAC_BITS;
			default: in_p.sres = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DVW-1:0], req_valid};
		end
	end

	// restoring divider, one quotient bit per stage
	pipe_t       div_n [1:DVW];
	logic [32:0] dtmp;
	logic        dge;

	always_comb begin
		dtmp = '0;
		dge  = 1'b0;
		for (int j = 1; j <= DVW; j++) begin
			div_n[j]     = pipe_s[j-1];
			dtmp         = {pipe_s[j-1].rem, pipe_s[j-1].dvd[DVW-1]};
			dge          = dtmp >= {1'b0, pipe_s[j-1].mb};
			div_n[j].rem = dge ? 32'(dtmp - {1'b0, pipe_s[j-1].mb}) : dtmp[31:0];
			div_n[j].dvd = {pipe_s[j-1].dvd[DVW-2:0], dge};
		end
		div_n[1].prod = 64'(pipe_s[0].ma) * 64'(pipe_s[0].mb);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= in_p;
			for (int j = 1; j <= DVW; j++) begin
				pipe_s[j] <= div_n[j];
			end
		end
	end

	// rounding of the mul and div magnitudes
	fin_t  fin_n;
	pipe_t lp;
	logic  rnd;

	always_comb begin
		lp  = pipe_s[DVW];
		rnd = {1'b0, lp.rem, 1'b0} >= {2'b00, lp.mb};
		fin_n.use_mag = (lp.op == OP_MUL) || (lp.op == OP_DIV && !lp.dz);
		fin_n.neg     = lp.neg;
		fin_n.mag     = (lp.op == OP_MUL)
			? ((lp.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS)
			: (64'(lp.dvd) + 64'(rnd));
		fin_n.sres    = lp.sres;
		fin_n.sovf    = lp.sovf;
		fin_n.lt      = lp.lt;
		fin_n.eq      = lp.eq;
		fin_n.gt      = lp.gt;
		fin_n.dz      = lp.dz;
	end

	// sign, saturate, output register
	rsp_t rsp_n;

	always_comb begin
		rsp_n.a_less         = fin_s.lt;
		rsp_n.a_equal        = fin_s.eq;
		rsp_n.a_greater      = fin_s.gt;
		rsp_n.divide_by_zero = fin_s.dz;
		if (fin_s.use_mag) begin
			if (fin_s.neg) begin
				rsp_n.overflow   = fin_s.mag > 64'h8000_0000;
				rsp_n.result_raw = rsp_n.overflow ? RAW_MIN : 32'(-fin_s.mag[31:0]);
			end else begin
				rsp_n.overflow   = fin_s.mag > 64'h7fff_ffff;
				rsp_n.result_raw = rsp_n.overflow ? RAW_MAX : fin_s.mag[31:0];
			end
		end else begin
			rsp_n.overflow   = fin_s.sovf;
			rsp_n.result_raw = fin_s.sres;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_fin_s   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			vld_fin_s   <= vld_s[DVW];
			rsp_valid_q <= vld_fin_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s <= fin_n;
			rsp_q <= rsp_n;
		end
	end

	// a divide by zero never reports a value or a saturation
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_by_zero |-> rsp.result_raw == 32'sd0 && !rsp.overflow)
		else $error("divide by zero with nonzero result");

	// exactly one compare flag per transaction
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot({rsp.a_less, rsp.a_equal, rsp.a_greater}))
		else $error("compare flags not one-hot");

	// the pipe only holds while a finished response waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a waiting response");

	// a held pipe keeps the response
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed under stall");

endmodule

/* bench/fixed_point_alu_tb.sv */
// self-checking testbench of the fixed-point alu with a reference predictor
`timescale 1ns / 100ps

module fixed_point_alu_tb;
	import fpa_pkg::*;

	localparam int FRAC = 8;
	localparam int LATENCY = FRAC + 35;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int mismatches;
	int sent_count;
	bit stim_done;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_sender;

	fixed_point_alu #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [31:0] saturate(input logic signed [65:0] x,
			inout logic ovf);
		if (x > 66'sd2147483647) begin
			ovf = 1'b1;
			return RAW_MAX;
		end
		if (x < -66'sd2147483648) begin
			ovf = 1'b1;
			return RAW_MIN;
		end
		return x[31:0];
	endfunction

	function automatic rsp_t alu_result(input req_t r);
		rsp_t o;
		logic signed [65:0] a, b, s;
		logic [65:0] ma, mb, q, rem;
		logic neg;
		logic ovf;
		a = r.operand_a;
		b = r.operand_b;
		ovf = 1'b0;
		o = '0;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		case (r.req_type)
			OP_ADD: o.result_raw = saturate(a + b, ovf);
			OP_SUB: o.result_raw = saturate(a - b, ovf);
			OP_MUL: begin
				q = (ma * mb + (66'd1 << (FRAC - 1))) >> FRAC;
				s = neg ? -$signed(q) : $signed(q);
				o.result_raw = saturate(s, ovf);
			end
			OP_DIV: begin
				if (b == 0) begin
					o.divide_by_zero = 1'b1;
				end else begin
					ma = ma << FRAC;
					q = ma / mb;
					rem = ma % mb;
					if (2 * rem >= mb)
						q = q + 1;
					s = neg ? -$signed(q) : $signed(q);
					o.result_raw = saturate(s, ovf);
				end
			end
			OP_MIN: o.result_raw = a < b ? r.operand_a : r.operand_b;
			OP_MAX: o.result_raw = a > b ? r.operand_a : r.operand_b;
			OP_INC: o.result_raw = saturate(a + 1, ovf);
			OP_DEC: o.result_raw = saturate(a - 1, ovf);
			OP_I2F: o.result_raw = saturate(a <<< FRAC, ovf);
			OP_F2I: o.result_raw = r.operand_a >>> FRAC;
			default: o.result_raw = '0;
		endcase
		o.overflow = ovf;
		o.a_less = a < b;
		o.a_equal = a == b;
		o.a_greater = a > b;
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 600);
			1: return -$urandom_range(0, 600);
			2: return RAW_MAX - $urandom_range(0, 3);
			3: return RAW_MIN + $urandom_range(0, 3);
			4: return $urandom_range(0, 65535) << $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(input logic [3:0] op, input logic [31:0] a,
			input logic [31:0] b);
		req_t r;
		r.req_type = op;
		r.operand_a = a;
		r.operand_b = b;
		pending_reqs.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!(req_valid && req_stall)) begin
			if (pending_reqs.size() > 0 && !hold_sender &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_reqs[0];
				expected_rsps.push_back(alu_result(pending_reqs[0]));
				void'(pending_reqs.pop_front());
				sent_count <= sent_count + 1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected transaction %p", rsp);
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp !== exp_rsp) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", exp_rsp, rsp);
					end
				end
			end
			rsp_stall <= $urandom_range(0, 99) < recv_stall_pct;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int phase;
		logic [3:0] op;
		mismatches = 0;
		sent_count = 0;
		stim_done = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_sender = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners: saturation, rounding, divide by zero, ties, bad opcodes
		add_req(OP_ADD, RAW_MAX, 1);
		add_req(OP_SUB, RAW_MIN, 1);
		add_req(OP_MUL, RAW_MAX, RAW_MAX);
		add_req(OP_MUL, RAW_MIN, RAW_MIN);
		add_req(OP_MUL, 32'h80, 32'h1);
		add_req(OP_MUL, -32'sh80, 32'h1);
		add_req(OP_DIV, 32'h100, 0);
		add_req(OP_DIV, RAW_MAX, 1);
		add_req(OP_DIV, RAW_MIN, -1);
		add_req(OP_DIV, 1, 2);
		add_req(OP_DIV, -1, 2);
		add_req(OP_MIN, 5, 5);
		add_req(OP_MAX, RAW_MIN, RAW_MAX);
		add_req(OP_INC, RAW_MAX, 0);
		add_req(OP_DEC, RAW_MIN, 3);
		add_req(OP_I2F, RAW_MAX, RAW_MIN);
		add_req(OP_I2F, -32'sh800000, 0);
		add_req(OP_F2I, -1, 0);
		add_req(OP_F2I, RAW_MIN, RAW_MAX);
		add_req(4'd10, 1, 2);
		add_req(4'd15, 32'hffffffff, 32'hffffffff);

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 81; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 81; end
				3: begin send_idle_pct = 6; recv_stall_pct = 6; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			repeat (130) begin
				op = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 9))
					: 4'($urandom_range(10, 15));
				add_req(op, rand_operand(), $urandom_range(0, 9) == 0 ? 32'h0
					: rand_operand());
			end
			wait_drained();
			if (phase == 2) begin
				// with the pipe drained, the sender holds back one queued divide, then releases it
				hold_sender = 1;
				add_req(OP_DIV, RAW_MIN, 1);
				repeat (LATENCY) @(posedge clk);
				hold_sender = 0;
				wait_drained();
			end
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
sv/fpa_pkg.sv
sv/fixed_point_alu.sv
bench/fixed_point_alu_tb.sv
